FILE: design/sparse_triangular_solve_core_macros.svh
`ifndef SPARSE_TRIANGULAR_SOLVE_CORE_MACROS_SVH
`define SPARSE_TRIANGULAR_SOLVE_CORE_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define STS_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("sparse solve check failed: same-cycle rule");

// Next-cycle implication, checked at every rising clock edge outside reset.
`define STS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("sparse solve check failed: next-cycle rule");

`endif

FILE: design/sts_pkg.sv
`default_nettype none

package sts_pkg;

    localparam int IDX_W  = 12;
    localparam int DATA_W = 32;
    localparam int ACC_W  = 48;
    localparam int ACT_W  = 2;

    // Request kinds carried in the input tuser field.
    localparam logic [ACT_W-1:0] ACT_OPEN    = 2'd0;
    localparam logic [ACT_W-1:0] ACT_OFFDIAG = 2'd1;
    localparam logic [ACT_W-1:0] ACT_DIAG    = 2'd2;

    localparam logic [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    typedef struct packed {
        logic open_row;
        logic read_issue;
        logic mul_step;
        logic acc_update;
        logic div_start;
        logic div_step;
        logic finish;
    } sts_cmd_t;

    typedef struct packed {
        logic div_done;
        logic out_free;
    } sts_status_t;

endpackage

`default_nettype wire

FILE: design/sts_ctrl.sv
`default_nettype none

module sts_ctrl (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire logic [sts_pkg::ACT_W-1:0] in_action,
    input  sts_pkg::sts_status_t          status,
    output sts_pkg::sts_cmd_t             cmd
);
    import sts_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_ACC,
        ST_DIV,
        ST_FIN
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    always_comb begin
        state_next     = state_reg;
        cmd            = '0;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (in_action)
                        ACT_OPEN: begin
                            cmd.open_row = 1'b1;
                        end
                        ACT_OFFDIAG: begin
                            cmd.read_issue = 1'b1;
                            state_next     = ST_MUL;
                        end
                        ACT_DIAG: begin
                            cmd.div_start = 1'b1;
                            state_next    = ST_DIV;
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_MUL: begin
                cmd.mul_step = 1'b1;
                state_next   = ST_ACC;
            end
            ST_ACC: begin
                cmd.acc_update = 1'b1;
                state_next     = ST_IDLE;
            end
            ST_DIV: begin
                if (status.div_done) begin
                    state_next = ST_FIN;
                end else begin
                    cmd.div_step = 1'b1;
                end
            end
            ST_FIN: begin
                if (status.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

FILE: design/sts_datapath.sv
`default_nettype none

module sts_datapath #(
    parameter int MAX_ROWS  = 4096,
    parameter int FRAC_BITS = 16
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  sts_pkg::sts_cmd_t                     cmd,
    output sts_pkg::sts_status_t                  status,
    input  wire logic [sts_pkg::IDX_W-1:0]        in_index,
    input  wire logic signed [sts_pkg::DATA_W-1:0] in_value,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output logic [sts_pkg::IDX_W-1:0]             out_row,
    output logic [sts_pkg::DATA_W-1:0]            out_solution,
    output logic                                  out_saturated,
    output logic                                  out_divide_by_zero
);
    import sts_pkg::*;

    localparam int AW     = $clog2(MAX_ROWS);
    localparam int PROD_W = 2 * DATA_W;
    localparam int TERM_W = PROD_W - FRAC_BITS;
    localparam int DIFF_W = ((TERM_W > ACC_W) ? TERM_W : ACC_W) + 1;
    localparam int NUM_W  = ACC_W + FRAC_BITS;
    localparam int CNT_W  = $clog2(NUM_W + 1);
    localparam int TOP_W  = DIFF_W - ACC_W + 1;

    logic [DATA_W-1:0] store_mem [MAX_ROWS];

    // Row state.
    logic signed [ACC_W-1:0] acc_reg;
    logic [IDX_W-1:0]        row_reg;
    logic                    sticky_reg;

    // Off-diagonal path.
    logic signed [DATA_W-1:0] rd_data_reg;
    logic                     rd_range_reg;
    logic signed [DATA_W-1:0] coef_reg;
    logic signed [PROD_W-1:0] prod_reg;

    // Divider.
    logic [NUM_W-1:0]  num_reg;
    logic [DATA_W-1:0] dvs_reg;
    logic [DATA_W-1:0] rem_reg;
    logic [DATA_W:0]   quo_reg;
    logic              qovf_reg;
    logic              neg_reg;
    logic              dbz_reg;
    logic [CNT_W-1:0]  cnt_reg;

    // Output register.
    logic              out_valid_reg;
    logic [IDX_W-1:0]  out_row_reg;
    logic [DATA_W-1:0] out_sol_reg;
    logic              out_sat_reg;
    logic              out_dbz_reg;

    logic signed [TERM_W-1:0] term;
    logic signed [DIFF_W-1:0] diff;
    logic [TOP_W-1:0]         diff_top;
    logic                     acc_ovf;
    logic signed [ACC_W-1:0]  acc_next;
    logic                     sticky_next;

    logic [ACC_W-1:0]  acc_mag;
    logic [DATA_W-1:0] val_mag;
    logic [DATA_W:0]   trial;
    logic              trial_ge;
    logic [DATA_W-1:0] rem_next;

    logic [DATA_W:0]   limit;
    logic              clip;
    logic [DATA_W:0]   q_clamped;
    logic [DATA_W-1:0] sol_next;
    logic              sat_next;
    logic              row_in_range;
    logic              idx_in_range;

    // Accumulate: the product is floored by dropping its fraction bits, then the
    // 48-bit accumulator clamps and remembers that it did.
    always_comb begin
        term     = prod_reg[PROD_W-1:FRAC_BITS];
        diff     = DIFF_W'(acc_reg) - DIFF_W'(term);
        diff_top = diff[DIFF_W-1:ACC_W-1];
        acc_ovf  = !((&diff_top) || !(|diff_top));
        if (acc_ovf) begin
            acc_next    = diff[DIFF_W-1] ? ACC_MIN : ACC_MAX;
            sticky_next = 1'b1;
        end else begin
            acc_next    = diff[ACC_W-1:0];
            sticky_next = sticky_reg;
        end
    end

    // Restoring division, one quotient bit per step.
    always_comb begin
        acc_mag  = acc_reg[ACC_W-1] ? ACC_W'(-acc_reg) : ACC_W'(acc_reg);
        val_mag  = in_value[DATA_W-1] ? DATA_W'(-in_value) : DATA_W'(in_value);
        trial    = {rem_reg, num_reg[NUM_W-1]};
        trial_ge = (trial >= {1'b0, dvs_reg});
        rem_next = trial_ge ? DATA_W'(trial - {1'b0, dvs_reg}) : trial[DATA_W-1:0];
    end

    // Sign, clamp and the zero-divisor case.
    always_comb begin
        limit     = neg_reg ? {2'b01, {(DATA_W-1){1'b0}}} : {2'b00, {(DATA_W-1){1'b1}}};
        clip      = qovf_reg || (quo_reg > limit);
        q_clamped = clip ? limit : quo_reg;
        if (dbz_reg) begin
            sat_next = sticky_reg;
            if (acc_reg[ACC_W-1]) begin
                sol_next = {1'b1, {(DATA_W-1){1'b0}}};
            end else if (acc_reg != '0) begin
                sol_next = {1'b0, {(DATA_W-1){1'b1}}};
            end else begin
                sol_next = '0;
            end
        end else begin
            sat_next = sticky_reg || clip;
            sol_next = neg_reg ? (~q_clamped[DATA_W-1:0] + 1'b1) : q_clamped[DATA_W-1:0];
        end
    end

    assign row_in_range = (32'(row_reg) < MAX_ROWS);
    assign idx_in_range = (32'(in_index) < MAX_ROWS);

    always_ff @(posedge aclk) begin
        if (cmd.finish && row_in_range) begin
            store_mem[AW'(row_reg)] <= sol_next;
        end
        if (cmd.read_issue) begin
            rd_data_reg <= store_mem[AW'(in_index)];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.read_issue) begin
            rd_range_reg <= idx_in_range;
            coef_reg     <= in_value;
        end
        if (cmd.mul_step) begin
            prod_reg <= PROD_W'(rd_range_reg ? rd_data_reg : DATA_W'(0)) * PROD_W'(coef_reg);
        end
        if (cmd.div_start) begin
            num_reg  <= {acc_mag, {FRAC_BITS{1'b0}}};
            dvs_reg  <= val_mag;
            rem_reg  <= '0;
            quo_reg  <= '0;
            qovf_reg <= 1'b0;
            neg_reg  <= acc_reg[ACC_W-1] ^ in_value[DATA_W-1];
        end else if (cmd.div_step) begin
            num_reg  <= {num_reg[NUM_W-2:0], 1'b0};
            rem_reg  <= rem_next;
            quo_reg  <= {quo_reg[DATA_W-1:0], trial_ge};
            qovf_reg <= qovf_reg || quo_reg[DATA_W];
        end
        if (cmd.finish) begin
            out_row_reg <= row_reg;
            out_sol_reg <= sol_next;
            out_sat_reg <= sat_next;
            out_dbz_reg <= dbz_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg       <= '0;
            row_reg       <= '0;
            sticky_reg    <= 1'b0;
            dbz_reg       <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.open_row) begin
                acc_reg    <= ACC_W'(in_value);
                row_reg    <= in_index;
                sticky_reg <= 1'b0;
            end else if (cmd.acc_update) begin
                acc_reg    <= acc_next;
                sticky_reg <= sticky_next;
            end
            if (cmd.div_start) begin
                dbz_reg <= (in_value == '0);
                cnt_reg <= CNT_W'(NUM_W);
            end else if (cmd.div_step) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
            if (cmd.finish) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign status.div_done = (cnt_reg == '0) || dbz_reg;
    assign status.out_free = !out_valid_reg || out_ready;

    assign out_valid          = out_valid_reg;
    assign out_row            = out_row_reg;
    assign out_solution       = out_sol_reg;
    assign out_saturated      = out_sat_reg;
    assign out_divide_by_zero = out_dbz_reg;

endmodule

`default_nettype wire

FILE: design/sparse_triangular_solve_core.sv
// Row-streamed sparse triangular solver in signed fixed point (Q16.16 by default).
// Each row is sent as one open request carrying the row index and right-hand
// side, any number of off-diagonal requests (column, coefficient) whose columns
// are already solved, and one diagonal request that divides, stores and emits the
// solved entry, so both forward and backward substitution fit. One request is
// worked on at a time: an open request loads the row state, an off-diagonal
// request runs a solution store read, a 32x32 multiply and a 48-bit subtract and
// clamp, and a diagonal request runs the restoring divider that produces one
// quotient bit per cycle over a 48 + FRAC_BITS bit dividend; a zero diagonal
// skips the divider. The result sits in an output register, so following
// requests are taken while it waits; only a second diagonal holds in its last
// cycle until the first result is taken. The solution store has no reset and
// needs no clearing: reading a column that was never solved gives an arbitrary
// value. Indexes at or above MAX_ROWS read as zero and are not written.
`default_nettype none

`include "sparse_triangular_solve_core_macros.svh"

module sparse_triangular_solve_core #(
    parameter int MAX_ROWS  = 4096,
    parameter int FRAC_BITS = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,   // index[11:0], value[43:12], zero[47:44]
    input  wire logic [1:0]  s_tuser,   // action[1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata,   // row[11:0], solution[43:12], zero[47:44]
    output logic [1:0]       m_tuser    // saturated[0], divide_by_zero[1]
);
    import sts_pkg::*;

    sts_cmd_t    cmd;
    sts_status_t status;

    logic [IDX_W-1:0]  out_row;
    logic [DATA_W-1:0] out_solution;
    logic              out_saturated;
    logic              out_divide_by_zero;

    // The controller sequences each request; all arithmetic and storage live in
    // the datapath.
    sts_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_action (s_tuser),
        .status    (status),
        .cmd       (cmd)
    );

    sts_datapath #(
        .MAX_ROWS  (MAX_ROWS),
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cmd                (cmd),
        .status             (status),
        .in_index           (s_tdata[11:0]),
        .in_value           (s_tdata[43:12]),
        .out_valid          (m_tvalid),
        .out_ready          (m_tready),
        .out_row            (out_row),
        .out_solution       (out_solution),
        .out_saturated      (out_saturated),
        .out_divide_by_zero (out_divide_by_zero)
    );

    assign m_tdata = {4'd0, out_solution, out_row};
    assign m_tuser = {out_divide_by_zero, out_saturated};

    // A finishing diagonal never overlaps with a newly taken request.
    `STS_ASSERT_SAME(a_fin_no_accept, aclk, aresetn, cmd.finish, !(s_tvalid && s_tready))
    // A finished diagonal always shows its result in the next cycle.
    `STS_ASSERT_NEXT(a_fin_shows_result, aclk, aresetn, cmd.finish, m_tvalid)
    // The off-diagonal path runs read, multiply and accumulate back to back.
    `STS_ASSERT_NEXT(a_read_then_mul, aclk, aresetn, cmd.read_issue, cmd.mul_step)
    `STS_ASSERT_NEXT(a_mul_then_acc, aclk, aresetn, cmd.mul_step, cmd.acc_update)

endmodule

`default_nettype wire

FILE: verif/tb.sv
`timescale 1ns / 1ps

module tb;

    import sts_pkg::*;

    // Fixed-point format and solution store depth, as instantiated below.
    localparam int FRAC      = 16;
    localparam int ROWS      = 4096;

    // Action code 3 is not a defined request; the solver must ignore it.
    localparam logic [ACT_W-1:0] ACT_IGNORE = 2'd3;

    // Stimulus size and the cycle limit without any handshake. The limit lies far
    // beyond the slowest request, a divide, plus the longest sender gap and
    // receiver stall, so reaching it means a hang.
    localparam int ITEM_TARGET = 500;
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_WAIT  = 120;

    typedef struct packed {
        logic [ACT_W-1:0]  action;
        logic [IDX_W-1:0]  index;
        logic [DATA_W-1:0] value;
    } stream_req_t;

    typedef struct packed {
        logic [IDX_W-1:0]  row;
        logic [DATA_W-1:0] solution;
        logic              saturated;
        logic              div_zero;
    } solved_entry_t;

    logic              aclk     = 1'b0;
    logic              aresetn  = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [47:0]       s_tdata  = '0;  // index[11:0], value[43:12], zero[47:44]
    logic [1:0]        s_tuser  = '0;  // action[1:0]
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [47:0]       m_tdata;        // row[11:0], solution[43:12], zero[47:44]
    logic [1:0]        m_tuser;        // saturated[0], divide_by_zero[1]

    sparse_triangular_solve_core #(
        .MAX_ROWS  (ROWS),
        .FRAC_BITS (FRAC)
    ) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // Requests waiting to be sent, and solved entries the solver still owes us.
    stream_req_t   pending_reqs[$];
    solved_entry_t solved_expect[$];

    // Our own copy of the solver state, advanced on every accepted request.
    logic [DATA_W-1:0]       sol_store[0:ROWS-1];
    logic signed [ACC_W-1:0] acc_q;
    logic [IDX_W-1:0]        row_q;
    logic                    sticky_q;

    // Generator bookkeeping: which rows hold a solved entry. Off-diagonal
    // requests only name such columns, since an unsolved column reads garbage.
    logic [IDX_W-1:0]        gen_row;
    bit                      gen_solved[0:ROWS-1];
    int                      solved_cols[$];
    int                      gen_items;

    int mismatches   = 0;
    int rows_checked = 0;
    int dbz_seen     = 0;
    int sat_seen     = 0;
    int ignored_sent = 0;

    // Applies one accepted request to the solver state and, for a diagonal
    // request, queues the solved entry the solver has to return.
    task automatic apply_request(input stream_req_t req);
        longint              prod;
        longint              diff;
        longint              mag_signed;
        longint unsigned     mag_a;
        longint unsigned     mag_d;
        longint unsigned     ip;
        longint unsigned     rem;
        longint unsigned     quo;
        longint unsigned     limit;
        logic                neg;
        logic                clip;
        logic signed [31:0]  val;
        solved_entry_t       res;
        val = req.value;
        case (req.action)
            ACT_OPEN: begin
                acc_q    = {{(ACC_W-DATA_W){val[31]}}, val};
                row_q    = req.index;
                sticky_q = 1'b0;
            end
            ACT_OFFDIAG: begin
                // Exact product, then a floor shift back to the fixed-point grid.
                prod = longint'($signed(sol_store[req.index])) * longint'(val);
                diff = longint'(acc_q) - (prod >>> FRAC);
                if (diff > longint'($signed(ACC_MAX))) begin
                    diff     = longint'($signed(ACC_MAX));
                    sticky_q = 1'b1;
                end
                if (diff < longint'($signed(ACC_MIN))) begin
                    diff     = longint'($signed(ACC_MIN));
                    sticky_q = 1'b1;
                end
                acc_q = diff[ACC_W-1:0];
            end
            ACT_DIAG: begin
                res.row       = row_q;
                res.saturated = sticky_q;
                res.div_zero  = 1'b0;
                if (val == 0) begin
                    // Zero diagonal: the result saturates by the sign of the sum.
                    res.div_zero = 1'b1;
                    if (acc_q > 0)
                        res.solution = 32'h7FFF_FFFF;
                    else if (acc_q < 0)
                        res.solution = 32'h8000_0000;
                    else
                        res.solution = '0;
                end else begin
                    neg        = acc_q[ACC_W-1] ^ val[31];
                    mag_signed = longint'(acc_q);
                    if (mag_signed < 0)
                        mag_signed = -mag_signed;
                    mag_a      = mag_signed;
                    mag_signed = longint'(val);
                    if (mag_signed < 0)
                        mag_signed = -mag_signed;
                    mag_d      = mag_signed;
                    ip         = mag_a / mag_d;
                    rem        = mag_a % mag_d;
                    limit      = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
                    clip       = 1'b0;
                    // Truncating divide on magnitudes, clipped to 32 bits.
                    if (ip > (64'd1 << (DATA_W - FRAC))) begin
                        clip = 1'b1;
                        quo  = limit;
                    end else begin
                        quo = (ip << FRAC) + ((rem << FRAC) / mag_d);
                        if (quo > limit) begin
                            clip = 1'b1;
                            quo  = limit;
                        end
                    end
                    if (clip)
                        res.saturated = 1'b1;
                    res.solution = neg ? 32'(-quo) : 32'(quo);
                end
                sol_store[row_q] = res.solution;
                solved_expect = {solved_expect, res};
            end
            default: begin
                // Undefined action: no state change and no result.
            end
        endcase
    endtask

    task automatic queue_request(input logic [ACT_W-1:0] act, input logic [IDX_W-1:0] idx,
                                 input logic [DATA_W-1:0] val);
        stream_req_t req;
        req.action = act;
        req.index  = idx;
        req.value  = val;
        pending_reqs = {pending_reqs, req};
        if (act == ACT_OPEN) begin
            gen_row = idx;
        end else if (act == ACT_DIAG && !gen_solved[gen_row]) begin
            gen_solved[gen_row] = 1'b1;
            solved_cols = {solved_cols, int'(gen_row)};
        end
        if (act == ACT_IGNORE)
            ignored_sent++;
        else
            gen_items++;
    endtask

    function automatic logic [IDX_W-1:0] pick_column();
        return IDX_W'(solved_cols[$urandom_range(0, solved_cols.size() - 1)]);
    endfunction

    function automatic logic [DATA_W-1:0] signed_mag(input int unsigned lo,
                                                     input int unsigned hi);
        logic [DATA_W-1:0] mag;
        mag = $urandom_range(hi, lo);
        return $urandom_range(0, 1) ? -mag : mag;
    endfunction

    // Right-hand sides: mostly within +/-64.0, sometimes the whole range.
    function automatic logic [DATA_W-1:0] rand_rhs();
        if ($urandom_range(0, 3) == 0)
            return $urandom;
        return signed_mag(0, 32'h003F_FFFF);
    endfunction

    // Off-diagonal coefficients: mostly within +/-2.0 so that rows stay sane.
    function automatic logic [DATA_W-1:0] rand_coef();
        if ($urandom_range(0, 7) == 0)
            return $urandom;
        return signed_mag(0, 32'h0002_0000);
    endfunction

    // Diagonals: mostly near 1.0, with zeros, tiny values and full-range values.
    function automatic logic [DATA_W-1:0] rand_diag();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 5)
            return '0;
        if (pick < 15)
            return signed_mag(1, 32'hFF);
        if (pick < 25)
            return $urandom;
        return signed_mag(32'h0000_8000, 32'h0004_0000);
    endfunction

    // Stimulus: a directed opening followed by random rows and noise.
    initial begin
        int unsigned pick;
        int unsigned n_off;
        gen_row   = '0;
        gen_items = 0;
        foreach (gen_solved[i])
            gen_solved[i] = 1'b0;

        // A diagonal before any open request divides the reset accumulator.
        queue_request(ACT_DIAG, 12'hABC, 32'h0001_0000);
        queue_request(ACT_IGNORE, 12'hFFF, 32'hFFFF_FFFF);
        // Stray off-diagonal, then a second diagonal on the same row by zero.
        queue_request(ACT_OFFDIAG, 12'd0, 32'h7FFF_FFFF);
        queue_request(ACT_DIAG, 12'd0, 32'h0000_0000);
        // Highest row index: 3.0 / -2.0.
        queue_request(ACT_OPEN, 12'hFFF, 32'h0003_0000);
        queue_request(ACT_DIAG, 12'h000, 32'hFFFE_0000);
        // Quotient clipping negative, then a repeated diagonal clipping positive.
        queue_request(ACT_OPEN, 12'd1, 32'h7FFF_FFFF);
        queue_request(ACT_OFFDIAG, 12'hFFF, 32'h8000_0000);
        queue_request(ACT_DIAG, 12'd0, 32'h0000_0001);
        queue_request(ACT_DIAG, 12'd0, 32'hFFFF_FFFF);
        // Accumulator driven past its negative limit, then a zero diagonal.
        queue_request(ACT_OPEN, 12'd2, 32'h8000_0000);
        queue_request(ACT_OFFDIAG, 12'd1, 32'h7FFF_FFFF);
        queue_request(ACT_OFFDIAG, 12'd1, 32'h7FFF_FFFF);
        queue_request(ACT_OFFDIAG, 12'd1, 32'h7FFF_FFFF);
        queue_request(ACT_DIAG, 12'd0, 32'h0000_0000);
        // Floor rounding of negative products and a full-scale divisor.
        queue_request(ACT_OPEN, 12'd3, 32'h0005_0000);
        queue_request(ACT_OFFDIAG, 12'd2, 32'h0000_0001);
        queue_request(ACT_OFFDIAG, 12'hFFF, 32'h0000_0003);
        queue_request(ACT_DIAG, 12'd0, 32'h8000_0000);
        // Zero diagonal with a zero sum, and with a negative sum.
        queue_request(ACT_OPEN, 12'd5, 32'h0000_0000);
        queue_request(ACT_DIAG, 12'd0, 32'h0000_0000);
        queue_request(ACT_OPEN, 12'd6, 32'hFFFF_0000);
        queue_request(ACT_IGNORE, 12'h000, 32'h0000_0000);
        queue_request(ACT_DIAG, 12'd0, 32'h0000_0000);

        // Random part: mostly complete rows that only reference solved columns,
        // with ignored requests, stray nonzeros and abandoned rows mixed in.
        while (gen_items < ITEM_TARGET) begin
            pick = $urandom_range(0, 99);
            if (pick < 82) begin
                queue_request(ACT_OPEN, IDX_W'($urandom), rand_rhs());
                n_off = $urandom_range(0, 5);
                repeat (n_off)
                    queue_request(ACT_OFFDIAG, pick_column(), rand_coef());
                queue_request(ACT_DIAG, IDX_W'($urandom), rand_diag());
            end else if (pick < 88) begin
                queue_request(ACT_IGNORE, IDX_W'($urandom), $urandom);
            end else if (pick < 94) begin
                queue_request(ACT_OFFDIAG, pick_column(), rand_coef());
            end else if (pick < 97) begin
                queue_request(ACT_DIAG, IDX_W'($urandom), rand_diag());
            end else begin
                queue_request(ACT_OPEN, IDX_W'($urandom), rand_rhs());
            end
        end

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // Drain: everything sent, every solved entry returned, then a margin
        // longer than the slowest divide to catch spurious results.
        while (pending_reqs.size() != 0 || s_tvalid || solved_expect.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);

        if (solved_expect.size() != 0) begin
            $display("%0d solved entries never returned", solved_expect.size());
            mismatches += solved_expect.size();
        end
        $display("Sent %0d requests (%0d ignored); checked %0d solved entries,",
                 gen_items + ignored_sent, ignored_sent, rows_checked);
        $display("  %0d with a zero diagonal, %0d flagged saturated; %0d mismatches.",
                 dbz_seen, sat_seen, mismatches);
        if (mismatches == 0) begin
            $display("sparse_triangular_solve_core regression: pass");
        end else begin
            $display("sparse_triangular_solve_core regression: fail");
        end
        $finish;
    end

    // Request driver. Works in bursts with random gaps; a request is held
    // unchanged until the solver takes it, and is predicted at that edge.
    stream_req_t cur_req = '0;
    int          burst_left = 0;
    int          gap_left   = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            acc_q    = '0;
            row_q    = '0;
            sticky_q = 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (s_tvalid)
                apply_request(cur_req);
            if (burst_left == 0) begin
                burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(30, 80)
                                                       : $urandom_range(1, 8);
                gap_left   = $urandom_range(0, 2) == 0 ? 0
                           : ($urandom_range(0, 7) == 0 ? $urandom_range(10, 20)
                                                        : $urandom_range(1, 4));
            end
            if (gap_left > 0) begin
                gap_left--;
                s_tvalid <= 1'b0;
            end else if (pending_reqs.size() != 0) begin
                cur_req = pending_reqs.pop_front();
                burst_left--;
                s_tvalid <= 1'b1;
                s_tuser  <= cur_req.action;
                s_tdata  <= {4'b0, cur_req.value, cur_req.index};
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Result monitor and receiver. Each returned entry is checked against
    // the oldest expectation; m_tready follows its own run/stall pattern.
    solved_entry_t got;
    solved_entry_t want;
    int            rx_run  = 0;
    int            rx_hold = 0;

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got.row       = m_tdata[11:0];
                got.solution  = m_tdata[43:12];
                got.saturated = m_tuser[0];
                got.div_zero  = m_tuser[1];
                if (solved_expect.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: row %0d solution %08h sat %0b dbz %0b",
                                 got.row, got.solution, got.saturated, got.div_zero);
                end else begin
                    want = solved_expect.pop_front();
                    rows_checked++;
                    if (want.div_zero)
                        dbz_seen++;
                    if (want.saturated)
                        sat_seen++;
                    if (got.row != want.row || got.solution != want.solution ||
                        got.saturated != want.saturated || got.div_zero != want.div_zero) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: want row %0d sol %08h sat %0b dbz %0b, %s",
                                     want.row, want.solution, want.saturated, want.div_zero,
                                     $sformatf("got row %0d sol %08h sat %0b dbz %0b",
                                               got.row, got.solution, got.saturated,
                                               got.div_zero));
                    end
                end
            end
            if (rx_run > 0) begin
                rx_run--;
                m_tready <= 1'b1;
            end else if (rx_hold > 0) begin
                rx_hold--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                rx_run  = $urandom_range(0, 3) == 0 ? $urandom_range(20, 60)
                                                    : $urandom_range(0, 6);
                rx_hold = $urandom_range(0, 9) == 0 ? $urandom_range(10, 30)
                                                    : $urandom_range(0, 4);
            end
        end
    end

    // Watchdog: while work is outstanding, a quiet stretch with no handshake that
    // reaches STALL_LIMIT ends the run as a failure.
    int quiet_cycles = 0;

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet_cycles = 0;
            end else if (pending_reqs.size() != 0 || s_tvalid || solved_expect.size() != 0) begin
                quiet_cycles++;
                if (quiet_cycles >= STALL_LIMIT) begin
                    $display("timeout: no request or result moved for %0d cycles",
                             quiet_cycles);
                    $display("sparse_triangular_solve_core regression: fail");
                    $finish;
                end
            end
        end
    end

endmodule
